// ===== rtl/core/hwf_pkg.sv =====
package hwf_pkg;

    localparam int CFG_W           = 11;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_SIZE_RESET  = 512;
    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_MAX_HEIGHT  = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 9;
    localparam int SUM_W      = 11;
    localparam int POS_W      = 10;
    localparam int GROUP_LEN  = 4;
    localparam int GROUP_W    = $clog2(GROUP_LEN);
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_LW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [GROUP_LEN-1:0][COEF_W-1:0] coef;
        logic [POS_W-1:0]                 row_lo;
        logic [POS_W-1:0]                 row_hi;
        logic [POS_W-1:0]                 col_lo;
        logic [POS_W-1:0]                 col_hi;
        logic                             eof;
    } t_job;

    typedef struct packed {
        logic                valid;
        logic [QUEUE_LW-1:0] level;
    } t_q_stat;

    // Rounds a size register down to even and clamps it to 2..maximum.
    function automatic logic [31:0] eff_size(input logic [CFG_W-1:0] v,
                                             input int unsigned mx);
        logic [31:0] ve;
        ve = {{(32 - CFG_W){1'b0}}, v[CFG_W-1:1], 1'b0};
        if (ve < 32'd2) begin
            ve = 32'd2;
        end else if (ve > 32'(mx)) begin
            ve = 32'(mx) & ~32'd1;
        end
        return ve;
    endfunction

endpackage

// ===== rtl/core/haar_wavelet_2d_forward_top.sv =====
// One-level forward 2D Haar transform of a grey frame.
// Pixels enter on s_axis in raster order, one 8-bit grey level per beat.
// The user must set frame width and height through the write port (index
// 0 and 1) only while the block is idle; the block does not enforce this.
// Odd or out-of-range sizes are rounded down to even and clamped to
// 2..MAX_WIDTH or 2..MAX_HEIGHT. Each 2x2 block yields four beats on
// m_axis in the order LL, HL, LH, HH, with the destination row and column
// in the quadrant layout. The completing pixel and its line-buffer read
// are registered, its block is written to the queue, then the LL beat
// loads the output register; the other three follow one per cycle while
// the receiver is ready. Even rows take one pixel per cycle while the
// queue has room; on odd rows intake is set by the single output register
// issuing one coefficient per cycle. A four-block queue sits between pixel
// intake and the output sequencer. When the receiver stalls, the queue
// fills and s_axis_tready drops; no beat is lost. Reset sets both sizes to
// 512 and the position to the frame start. The line buffer is not cleared.
module haar_wavelet_2d_forward_top #(
    parameter int MAX_WIDTH  = hwf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hwf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hwf_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [hwf_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [hwf_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // grey[7:0]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [hwf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // coefficient[8:0], out_row[18:9],
                                                            // out_col[28:19]
    output logic                            m_axis_tlast,   // end_of_frame
    output logic [0:0]                      m_axis_tuser    // last_of_group[0]
);

    import hwf_pkg::*;

    t_q_stat q_stat;
    t_job    push_job;
    t_job    head_job;
    logic    q_push;
    logic    q_pop;

    hwf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_grey     (s_axis_tdata[PIX_W-1:0]),
        .i_q_stat   (q_stat),
        .o_push     (q_push),
        .o_job      (push_job)
    );

    hwf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_stat  (q_stat),
        .o_head  (head_job)
    );

    hwf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_stat      (q_stat),
        .i_head        (head_job),
        .o_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_stat.level < QUEUE_LW'(QUEUE_DEPTH)))
        else $error("block queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_stat.valid)
        else $error("block queue read while empty");

    a_eof_on_hh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser[0])
        else $error("frame end flagged on a beat that is not HH");

endmodule

// ===== rtl/core/hwf_ram.sv =====
module hwf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/hwf_front.sv =====
module hwf_front #(
    parameter int MAX_WIDTH  = hwf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hwf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hwf_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [hwf_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [hwf_pkg::PIX_W-1:0]      i_grey,
    input  hwf_pkg::t_q_stat               i_q_stat,
    output logic                           o_push,
    output hwf_pkg::t_job                  o_job
);

    import hwf_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    function automatic logic [COEF_W-1:0] quarter(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] t;
        t = s[SUM_W-1] ? (s + $signed(SUM_W'(3))) : s;
        return COEF_W'(t >>> 2);
    endfunction

    logic [WW-1:0]    r_w;
    logic [HW-1:0]    r_h;
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;

    logic             r_s1_valid;
    logic             r_s1_odd_col;
    logic [PIX_W-1:0] r_s1_pix;
    logic [POS_W-1:0] r_s1_row_lo;
    logic [POS_W-1:0] r_s1_row_hi;
    logic [POS_W-1:0] r_s1_col_lo;
    logic [POS_W-1:0] r_s1_col_hi;
    logic             r_s1_eof;
    logic [PIX_W-1:0] r_a;
    logic [PIX_W-1:0] r_c;

    logic             accept;
    logic             row_end;
    logic             frame_end;
    logic             pending;
    logic [PIX_W-1:0] ram_q;
    logic [HW-1:0]    row_half;
    logic [WW-1:0]    col_half;
    logic signed [SUM_W-1:0] sa, sb, sc, sd;

    assign pending = r_s1_valid & r_s1_odd_col;
    assign o_ready = (QUEUE_LW'(i_q_stat.level) + QUEUE_LW'(pending))
                     < QUEUE_LW'(QUEUE_DEPTH);
    assign accept  = i_valid & o_ready;

    assign row_end   = (WW'(r_col) + WW'(1)) >= r_w;
    assign frame_end = row_end && ((HW'(r_row) + HW'(1)) >= r_h);
    assign row_half  = HW'(r_row >> 1);
    assign col_half  = WW'(r_col >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= WW'(eff_size(CFG_W'(CFG_SIZE_RESET), MAX_WIDTH));
            r_h <= HW'(eff_size(CFG_W'(CFG_SIZE_RESET), MAX_HEIGHT));
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FRAME_WIDTH: begin
                    r_w <= WW'(eff_size(i_cfg_data, MAX_WIDTH));
                end
                CFG_FRAME_HEIGHT: begin
                    r_h <= HW'(eff_size(i_cfg_data, MAX_HEIGHT));
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept & r_row[0];
            if (accept) begin
                if (row_end) begin
                    r_col <= '0;
                    r_row <= frame_end ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_odd_col <= r_col[0];
            r_s1_pix     <= i_grey;
            r_s1_row_lo  <= POS_W'(row_half);
            r_s1_row_hi  <= POS_W'(row_half + (r_h >> 1));
            r_s1_col_lo  <= POS_W'(col_half);
            r_s1_col_hi  <= POS_W'(col_half + (r_w >> 1));
            r_s1_eof     <= frame_end;
        end
        if (r_s1_valid && !r_s1_odd_col) begin
            r_a <= ram_q;
            r_c <= r_s1_pix;
        end
    end

    hwf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (accept & ~r_row[0]),
        .i_waddr (r_col),
        .i_wdata (i_grey),
        .i_re    (accept & r_row[0]),
        .i_raddr (r_col),
        .o_rdata (ram_q)
    );

    assign sa = $signed({3'b000, r_a});
    assign sb = $signed({3'b000, ram_q});
    assign sc = $signed({3'b000, r_c});
    assign sd = $signed({3'b000, r_s1_pix});

    assign o_push         = pending;
    assign o_job.coef[0]  = quarter(sa + sb + sc + sd);
    assign o_job.coef[1]  = quarter(sa - sb + sc - sd);
    assign o_job.coef[2]  = quarter(sa + sb - sc - sd);
    assign o_job.coef[3]  = quarter(sa - sb - sc + sd);
    assign o_job.row_lo   = r_s1_row_lo;
    assign o_job.row_hi   = r_s1_row_hi;
    assign o_job.col_lo   = r_s1_col_lo;
    assign o_job.col_hi   = r_s1_col_hi;
    assign o_job.eof      = r_s1_eof;

endmodule

// ===== rtl/core/hwf_queue.sv =====
module hwf_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hwf_pkg::t_job    i_job,
    input  logic             i_pop,
    output hwf_pkg::t_q_stat o_stat,
    output hwf_pkg::t_job    o_head
);

    import hwf_pkg::*;

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr;
    logic [QUEUE_AW-1:0] r_rptr;
    logic [QUEUE_LW-1:0] r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + QUEUE_LW'(1);
            end else if (i_pop && !i_push) begin
                r_level <= r_level - QUEUE_LW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    assign o_stat.valid = (r_level != '0);
    assign o_stat.level = r_level;
    assign o_head       = r_mem[r_rptr];

endmodule

// ===== rtl/core/hwf_back.sv =====
module hwf_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  hwf_pkg::t_q_stat                 i_q_stat,
    input  hwf_pkg::t_job                    i_head,
    output logic                             o_pop,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [hwf_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tlast,
    output logic [0:0]                       m_axis_tuser
);

    import hwf_pkg::*;

    localparam int PAD_W = OUT_DATA_W - COEF_W - 2 * POS_W;

    logic [GROUP_W-1:0] r_idx;
    logic               r_valid;
    logic [COEF_W-1:0]  r_coef;
    logic [POS_W-1:0]   r_row;
    logic [POS_W-1:0]   r_col;
    logic               r_last;
    logic               r_eof;

    logic               load;
    logic               idx_last;
    logic [COEF_W-1:0]  n_coef;
    logic [POS_W-1:0]   n_row;
    logic [POS_W-1:0]   n_col;

    assign load     = i_q_stat.valid & (~r_valid | m_axis_tready);
    assign idx_last = (r_idx == GROUP_W'(GROUP_LEN - 1));
    assign o_pop    = load & idx_last;

    always_comb begin
        n_coef = i_head.coef[r_idx];
        case (r_idx)
            2'd0: begin
                n_row = i_head.row_lo;
                n_col = i_head.col_lo;
            end
            2'd1: begin
                n_row = i_head.row_lo;
                n_col = i_head.col_hi;
            end
            2'd2: begin
                n_row = i_head.row_hi;
                n_col = i_head.col_lo;
            end
            default: begin
                n_row = i_head.row_hi;
                n_col = i_head.col_hi;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_idx   <= r_idx + GROUP_W'(1);
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_coef <= n_coef;
            r_row  <= n_row;
            r_col  <= n_col;
            r_last <= idx_last;
            r_eof  <= idx_last & i_head.eof;
        end
    end

    assign m_axis_tvalid   = r_valid;
    assign m_axis_tdata    = {{PAD_W{1'b0}}, r_col, r_row, r_coef};
    assign m_axis_tlast    = r_eof;
    assign m_axis_tuser[0] = r_last;

endmodule
